>>> sv/mag_pkg.sv
`timescale 1ns / 1ps
package mag_pkg;

  // array size; index and count widths below are fixed to suit it
  localparam int MAX_MICS = 8;

  // counter width for microphone indices and the pair walk
  localparam int CNT_W      = 4;
  localparam int SQRT_STEPS = 22;
  localparam int DIV_STEPS  = 45;
  localparam int STEP_W     = 6;

  localparam logic [19:0] SPEED_RST = 20'd343000;
  localparam logic [19:0] RATE_RST  = 20'd48000;
  localparam logic [3:0]  COUNT_RST = 4'd2;

  localparam logic [23:0] DELAY_SAT = 24'hFFFFFF;
  localparam logic [22:0] ALIAS_SAT = 23'h7FFFFF;

  // register map
  typedef enum logic [1:0] {
    REG_MIC_COUNT   = 2'd0,
    REG_SOUND_SPEED = 2'd1,
    REG_SAMPLE_RATE = 2'd2
  } cfg_reg_t;

  localparam logic KIND_PAIR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_BAD     = 1'b1;

  typedef struct packed {
    logic [2:0]         mic_index;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic [7:0]         capture_channel;
    logic               run_after;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  first_mic;
    logic [2:0]  second_mic;
    logic [20:0] pair_distance;
    logic [23:0] max_delay;
    logic [4:0]  pair_total;
    logic [20:0] min_spacing;
    logic [20:0] aperture;
    logic [22:0] alias_freq;
    logic        status;
    logic        last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK_FIRST, S_CHK_RD, S_CHK_SQ, S_CHK_TEST, S_INV,
    S_CAL_FIRST, S_CAL_RD, S_CAL_SQ, S_SQRT_INIT, S_SQRT, S_MUL,
    S_DLY_INIT, S_DLY_DIV, S_PAIR_OUT, S_CAL_NEXT, S_ALS_INIT,
    S_ALS_DIV, S_SUM_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_FIRST, OP_NEXT, OP_SQ_CLR, OP_SQ, OP_SQRT_INIT,
    OP_SQRT_STEP, OP_MUL, OP_DIV_INIT, OP_DIV_STEP, OP_LOAD_PAIR,
    OP_LOAD_SUM, OP_LOAD_INV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_alias;
    logic   store;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_bad;
    logic pair_bad;
    logic pair_last;
    logic sq_done;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> sv/mag_ctrl.sv
`timescale 1ns / 1ps
module mag_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_run,
  output logic            in_ready,
  input  mag_pkg::dp_sts_t sts,
  output mag_pkg::dp_cmd_t cmd
);
  import mag_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_run) begin
          state_nxt = sts.cfg_bad ? S_INV : S_CHK_FIRST;
        end
      end
      S_CHK_FIRST: state_nxt = S_CHK_RD;
      S_CHK_RD:    state_nxt = S_CHK_SQ;
      S_CHK_SQ:    if (sts.sq_done) state_nxt = S_CHK_TEST;
      S_CHK_TEST: begin
        if (sts.pair_bad)       state_nxt = S_INV;
        else if (sts.pair_last) state_nxt = S_CAL_FIRST;
        else                    state_nxt = S_CHK_RD;
      end
      S_INV:       if (sts.out_free) state_nxt = S_IDLE;
      S_CAL_FIRST: state_nxt = S_CAL_RD;
      S_CAL_RD:    state_nxt = S_CAL_SQ;
      S_CAL_SQ:    if (sts.sq_done) state_nxt = S_SQRT_INIT;
      S_SQRT_INIT: state_nxt = S_SQRT;
      S_SQRT:      if (sts.sqrt_done) state_nxt = S_MUL;
      S_MUL:       state_nxt = S_DLY_INIT;
      S_DLY_INIT:  state_nxt = S_DLY_DIV;
      S_DLY_DIV:   if (sts.div_done) state_nxt = S_PAIR_OUT;
      S_PAIR_OUT: begin
        if (sts.out_free) state_nxt = sts.pair_last ? S_ALS_INIT : S_CAL_NEXT;
      end
      S_CAL_NEXT:  state_nxt = S_CAL_RD;
      S_ALS_INIT:  state_nxt = S_ALS_DIV;
      S_ALS_DIV:   if (sts.div_done) state_nxt = S_SUM_OUT;
      S_SUM_OUT:   if (sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd           = '0;
    cmd.op        = OP_NONE;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.store = in_valid;
      end
      S_CHK_FIRST, S_CAL_FIRST: cmd.op = OP_FIRST;
      S_CHK_RD, S_CAL_RD:       cmd.op = OP_SQ_CLR;
      S_CHK_SQ, S_CAL_SQ:       cmd.op = OP_SQ;
      S_CHK_TEST: begin
        if (!sts.pair_bad && !sts.pair_last) cmd.op = OP_NEXT;
      end
      S_INV:       if (sts.out_free) cmd.op = OP_LOAD_INV;
      S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      S_SQRT:      cmd.op = OP_SQRT_STEP;
      S_MUL:       cmd.op = OP_MUL;
      S_DLY_INIT:  cmd.op = OP_DIV_INIT;
      S_DLY_DIV, S_ALS_DIV: cmd.op = OP_DIV_STEP;
      S_PAIR_OUT:  if (sts.out_free) cmd.op = OP_LOAD_PAIR;
      S_CAL_NEXT:  cmd.op = OP_NEXT;
      S_ALS_INIT: begin
        cmd.op        = OP_DIV_INIT;
        cmd.div_alias = 1'b1;
      end
      S_SUM_OUT:   if (sts.out_free) cmd.op = OP_LOAD_SUM;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> sv/mag_datapath.sv
`timescale 1ns / 1ps
module mag_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  mag_pkg::in_item_t in_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [19:0]       cfg_wdata,
  input  mag_pkg::dp_cmd_t  cmd,
  output mag_pkg::dp_sts_t  sts,
  output logic              out_valid,
  input  logic              out_ready,
  output mag_pkg::out_item_t out_data
);
  import mag_pkg::*;

  localparam int MI_W = (MAX_MICS > 1) ? $clog2(MAX_MICS) : 1;
  localparam logic [CNT_W:0] MAX_CNT = (CNT_W+1)'(MAX_MICS);
  localparam int WORD_W = 68;

  // configuration
  logic [3:0]  mic_count_r;
  logic [19:0] sound_speed_r, sample_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mic_count_r   <= COUNT_RST;
      sound_speed_r <= SPEED_RST;
      sample_rate_r <= RATE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MIC_COUNT:   mic_count_r   <= cfg_wdata[3:0];
        REG_SOUND_SPEED: sound_speed_r <= cfg_wdata;
        REG_SAMPLE_RATE: sample_rate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // microphone store, two registered read ports
  logic [WORD_W-1:0] mem [MAX_MICS];
  logic [WORD_W-1:0] rd_a_r, rd_b_r;
  logic [CNT_W-1:0]  i_r, j_r;
  logic [CNT_W-1:0]  wr_idx;

  assign wr_idx = CNT_W'(in_data.mic_index);

  always_ff @(posedge clk) begin
    if (cmd.store && ({1'b0, wr_idx} < MAX_CNT)) begin
      mem[wr_idx[MI_W-1:0]] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z,
                                in_data.capture_channel};
    end
    rd_a_r <= mem[i_r[MI_W-1:0]];
    rd_b_r <= mem[j_r[MI_W-1:0]];
  end

  // pair walk
  logic pair_last;
  assign pair_last = (j_r == mic_count_r - 4'd1) && (i_r == mic_count_r - 4'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.op == OP_FIRST) begin
      i_r <= '0;
      j_r <= CNT_W'(1);
    end else if (cmd.op == OP_NEXT) begin
      if (j_r == mic_count_r - 4'd1) begin
        i_r <= i_r + 4'd1;
        j_r <= i_r + 4'd2;
      end else begin
        j_r <= j_r + 4'd1;
      end
    end
  end

  // shared step counter
  logic [STEP_W-1:0] step_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      case (cmd.op)
        OP_SQ_CLR, OP_SQRT_INIT, OP_DIV_INIT:  step_r <= '0;
        OP_SQ, OP_SQRT_STEP, OP_DIV_STEP:      step_r <= step_r + 1'b1;
        default: ;
      endcase
    end
  end

  // squared distance: one axis a cycle through one multiplier
  logic signed [20:0] dx, dy, dz, dsel;
  logic signed [41:0] sq;
  logic [43:0]        acc_r;

  assign dx = 21'(signed'(rd_b_r[67:48])) - 21'(signed'(rd_a_r[67:48]));
  assign dy = 21'(signed'(rd_b_r[47:28])) - 21'(signed'(rd_a_r[47:28]));
  assign dz = 21'(signed'(rd_b_r[27:8]))  - 21'(signed'(rd_a_r[27:8]));

  always_comb begin
    case (step_r[1:0])
      2'd0:    dsel = dx;
      2'd1:    dsel = dy;
      default: dsel = dz;
    endcase
  end
  assign sq = dsel * dsel;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQ_CLR) begin
      acc_r <= '0;
    end else if (cmd.op == OP_SQ) begin
      acc_r <= acc_r + {2'b00, sq};
    end
  end

  // integer square root, one result bit a cycle
  logic [43:0] sv_r;
  logic [24:0] srem_r, srem_sh, strial;
  logic [21:0] root_r;
  logic        sge;

  assign srem_sh = {srem_r[22:0], sv_r[43:42]};
  assign strial  = {1'b0, root_r, 2'b01};
  assign sge     = srem_sh >= strial;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQRT_INIT) begin
      sv_r   <= acc_r;
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.op == OP_SQRT_STEP) begin
      sv_r   <= {sv_r[41:0], 2'b00};
      srem_r <= sge ? (srem_sh - strial) : srem_sh;
      root_r <= {root_r[20:0], sge};
    end
  end

  // delay product
  logic [40:0] prod_r;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_MUL) begin
      prod_r <= root_r[20:0] * sample_rate_r;
    end
  end

  // restoring divider, one quotient bit a cycle, shared by delay and alias
  logic [44:0] nq_r;
  logic [20:0] den_r, drem_r;
  logic [21:0] drem_sh;
  logic        dge;
  logic [20:0] mn_r, mx_r;

  assign drem_sh = {drem_r, nq_r[44]};
  assign dge     = drem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV_INIT) begin
      drem_r <= '0;
      if (cmd.div_alias) begin
        nq_r  <= {22'd0, sound_speed_r, 3'b000};
        den_r <= mn_r;
      end else begin
        nq_r  <= {prod_r, 4'b0000};
        den_r <= {1'b0, sound_speed_r};
      end
    end else if (cmd.op == OP_DIV_STEP) begin
      drem_r <= dge ? 21'(drem_sh - {1'b0, den_r}) : drem_sh[20:0];
      nq_r   <= {nq_r[43:0], dge};
    end
  end

  // run statistics and kept spacing, latched as the summary division starts
  logic [5:0]  k_r;
  logic [20:0] least_r, greatest_r;
  logic [20:0] pair_dist;
  assign pair_dist = root_r[20:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      least_r    <= '0;
      greatest_r <= '0;
    end else if (cmd.op == OP_DIV_INIT && cmd.div_alias) begin
      least_r    <= mn_r;
      greatest_r <= mx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIRST) begin
      k_r <= '0;
    end else if (cmd.op == OP_LOAD_PAIR) begin
      k_r <= k_r + 6'd1;
      if (k_r == '0 || pair_dist < mn_r) mn_r <= pair_dist;
      if (k_r == '0 || pair_dist > mx_r) mx_r <= pair_dist;
    end
  end

  // result register
  logic       out_valid_r;
  out_item_t  out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_LOAD_PAIR || cmd.op == OP_LOAD_SUM ||
                 cmd.op == OP_LOAD_INV) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_PAIR: begin
        out_r               <= '0;
        out_r.result_kind   <= KIND_PAIR;
        out_r.first_mic     <= i_r[2:0];
        out_r.second_mic    <= j_r[2:0];
        out_r.pair_distance <= pair_dist;
        out_r.max_delay     <= (|nq_r[44:24]) ? DELAY_SAT : nq_r[23:0];
        out_r.status        <= STAT_OK;
      end
      OP_LOAD_SUM: begin
        out_r             <= '0;
        out_r.result_kind <= KIND_SUMMARY;
        out_r.pair_total  <= k_r[4:0];
        out_r.min_spacing <= least_r;
        out_r.aperture    <= greatest_r;
        out_r.alias_freq  <= (|nq_r[44:23]) ? ALIAS_SAT : nq_r[22:0];
        out_r.status      <= STAT_OK;
        out_r.last        <= 1'b1;
      end
      OP_LOAD_INV: begin
        out_r             <= '0;
        out_r.result_kind <= KIND_SUMMARY;
        out_r.status      <= STAT_BAD;
        out_r.last        <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status to the controller
  assign sts.cfg_bad   = (mic_count_r < 4'd2) || ({1'b0, mic_count_r} > MAX_CNT) ||
                         (sound_speed_r == '0);
  assign sts.pair_bad  = (rd_a_r[7:0] == rd_b_r[7:0]) || (acc_r == '0);
  assign sts.pair_last = pair_last;
  assign sts.sq_done   = step_r == STEP_W'(2);
  assign sts.sqrt_done = step_r == STEP_W'(SQRT_STEPS - 1);
  assign sts.div_done  = step_r == STEP_W'(DIV_STEPS - 1);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

>>> sv/mic_array_geometry_check.sv
`timescale 1ns / 1ps
// Microphone array geometry check. Each input transaction loads one microphone
// (position in 1/16 mm and capture channel) into its slot; a transaction with
// run_after set then checks microphones 0 to mic_count-1. A shared channel or
// two coincident microphones, a bad count or a zero sound speed give a single
// invalid result. Otherwise one result per pair (i < j, index order) carries
// the distance and the largest delay in 1/256 samples, followed by a summary
// with pair count, minimum spacing, aperture and aliasing frequency. Input is
// taken when idle; a run makes a check pass over the pairs, then per pair a
// squared distance on one multiplier, a bit-serial square root and a
// bit-serial divider, and one more division for the summary. Input is held
// off during a run.
module mic_array_geometry_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mag_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mag_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [19:0]        cfg_wdata
);
  import mag_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_run   (in_data.run_after),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mag_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/mag_checker.sv
`timescale 1ns / 1ps
module mag_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input mag_pkg::out_item_t out_data
);
  import mag_pkg::*;

  // stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // only the final result of a run may be a summary
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.result_kind == KIND_PAIR)
    else $error("non-final result not a pair");

  // invalid status only on a final summary
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_BAD |->
      out_data.last && out_data.result_kind == KIND_SUMMARY)
    else $error("invalid status misplaced");

  // pairs come with ascending indices
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_PAIR |->
      out_data.first_mic < out_data.second_mic)
    else $error("pair indices out of order");

endmodule

bind mic_array_geometry_check mag_checker u_mag_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
